>>> rtl/csrq_pkg.sv
package csrq_pkg;

    localparam int QueueDepthDef = 8;

    localparam logic [2:0] MODE_ENQ  = 3'd0;
    localparam logic [2:0] MODE_ANS  = 3'd1;
    localparam logic [2:0] MODE_HB   = 3'd2;
    localparam logic [2:0] MODE_TICK = 3'd3;
    localparam logic [2:0] MODE_NMT  = 3'd4;

    localparam logic [1:0] KIND_TX   = 2'd0;
    localparam logic [1:0] KIND_ANS  = 2'd1;
    localparam logic [1:0] KIND_STAT = 2'd2;

    localparam logic [2:0] EV_NONE    = 3'd0;
    localparam logic [2:0] EV_OK      = 3'd1;
    localparam logic [2:0] EV_UNEXP   = 3'd2;
    localparam logic [2:0] EV_BAD_HB  = 3'd3;
    localparam logic [2:0] EV_OVF     = 3'd4;
    localparam logic [2:0] EV_TIMEOUT = 3'd5;
    localparam logic [2:0] EV_ABORT   = 3'd6;

    localparam logic [1:0] REG_NODE_ID = 2'd0;
    localparam logic [1:0] REG_TIMEOUT = 2'd1;
    localparam logic [1:0] REG_RESEND  = 2'd2;
    localparam logic [1:0] REG_HB_OFF  = 2'd3;

    localparam logic [7:0] NMT_START = 8'h01;
    localparam logic [7:0] NMT_STOP  = 8'h02;
    localparam logic [7:0] NMT_PREOP = 8'h80;
    localparam logic [7:0] NMT_RST_N = 8'h81;
    localparam logic [7:0] NMT_RST_C = 8'h82;
    localparam logic [7:0] SDO_ABORT = 8'h80;

    localparam logic [1:0] NS_PREOP = 2'd0;
    localparam logic [1:0] NS_OPER  = 2'd1;
    localparam logic [1:0] NS_STOP  = 2'd2;

    typedef struct packed {
        logic        nmt;
        logic        ans;
        logic [7:0]  sub;
        logic [15:0] idx;
        logic [7:0]  cmd;
    } hdr_t;

    typedef struct packed {
        hdr_t        hdr;
        logic [31:0] pay;
    } entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_STOP_PUSH,
        ST_NEXT_POP,
        ST_RD,
        ST_RD_WAIT,
        ST_TX,
        ST_STATUS
    } state_t;

endpackage

>>> rtl/csrq_mem.sv
module csrq_mem
    import csrq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QueueDepthDef,
    localparam int AW = $clog2(QUEUE_DEPTH)
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  entry_t        wdata,
    input  logic [AW-1:0] raddr,
    output entry_t        rdata
);

    entry_t mem [QUEUE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/canopen_sdo_request_queue.sv
// Sequence: an accepted request is decoded and ends with a final status strobe; each
// message sent from the queue adds read, read wait and transmit; popping the front after
// an answer or timeout adds a pop step, and queueing an NMT stop adds a push step.
// Throughput: one item at a time; busy stays high until the final status, so no new request
// is taken before then; queue reads pass the memory output and front registers.
// Reset: asynchronous active-low; queue empty, counters, NMT state and error cleared.
module canopen_sdo_request_queue
    import csrq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QueueDepthDef,
    localparam int AW = $clog2(QUEUE_DEPTH),
    localparam int CW = $clog2(QUEUE_DEPTH + 1)
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  mode,
    input  logic [7:0]  cmd,
    input  logic [15:0] obj_index,
    input  logic [7:0]  obj_subindex,
    input  logic [31:0] payload,
    input  logic        needs_answer,
    input  logic [3:0]  frame_length,
    output logic        strobe,
    output logic [1:0]  kind,
    output logic        is_nmt,
    output logic [7:0]  out_cmd,
    output logic [15:0] out_index,
    output logic [7:0]  out_subindex,
    output logic [31:0] out_payload,
    output logic        last,
    output logic        device_error,
    output logic [1:0]  nmt_now,
    output logic [2:0]  event_res
);

    logic [6:0]  node_id_reg;
    logic [15:0] timeout_reg;
    logic [7:0]  resend_lim_reg;
    logic        hb_off_reg;

    state_t state_reg, state_next;
    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic [16:0] wait_reg, wait_next;
    logic [8:0]  resend_reg, resend_next;
    logic [1:0]  nmt_reg, nmt_next;
    logic        err_reg, err_next;
    logic [2:0]  ev_reg, ev_next;
    logic        pop_tx_reg, pop_tx_next;   // pop no-answer front after transmit
    logic        loop_reg, loop_next;       // keep walking after transmit

    logic [2:0]  mode_reg;
    logic [7:0]  cmd_reg;
    logic [15:0] idx_reg;
    logic [7:0]  sub_reg;
    logic [31:0] pay_reg;
    logic        ans_reg;
    logic [3:0]  flen_reg;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    entry_t        mem_wdata;
    entry_t        mem_rdata;
    entry_t        front_reg;

    logic        o_strobe_next;
    logic [1:0]  o_kind_next;
    logic        o_nmt_next;
    logic [7:0]  o_cmd_next;
    logic [15:0] o_idx_next;
    logic [7:0]  o_sub_next;
    logic [31:0] o_pay_next;
    logic        o_last_next;

    csrq_mem #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_mem
    (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (head_reg),
        .rdata (mem_rdata)
    );

    function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] a, logic [CW-1:0] b);
        logic [CW:0] s;
        s = {{(CW+1-AW){1'b0}}, a} + {1'b0, b};
        if (s >= (CW+1)'(QUEUE_DEPTH))
        begin
            s = s - (CW+1)'(QUEUE_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    logic full;
    logic front_match;
    hdr_t nmt_hdr_in;
    hdr_t stop_hdr;
    hdr_t enq_hdr;

    assign full        = (count_reg == CW'(QUEUE_DEPTH));
    assign front_match = (count_reg != '0) && (front_reg.hdr.idx == idx_reg)
                         && (front_reg.hdr.sub == sub_reg);
    assign nmt_hdr_in  = '{nmt: 1'b1, ans: 1'b0, sub: 8'd0,
                           idx: {9'd0, node_id_reg}, cmd: cmd_reg};
    assign stop_hdr    = '{nmt: 1'b1, ans: 1'b0, sub: 8'd0,
                           idx: {9'd0, node_id_reg}, cmd: NMT_STOP};
    assign enq_hdr     = '{nmt: 1'b0, ans: ans_reg, sub: sub_reg,
                           idx: idx_reg, cmd: cmd_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_id_reg    <= 7'd1;
            timeout_reg    <= '0;
            resend_lim_reg <= '0;
            hb_off_reg     <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_NODE_ID: node_id_reg    <= cfg_data[6:0];
                REG_TIMEOUT: timeout_reg    <= cfg_data;
                REG_RESEND:  resend_lim_reg <= cfg_data[7:0];
                REG_HB_OFF:  hb_off_reg     <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            mode_reg <= mode;
            cmd_reg  <= cmd;
            idx_reg  <= obj_index;
            sub_reg  <= obj_subindex;
            pay_reg  <= payload;
            ans_reg  <= needs_answer;
            flen_reg <= frame_length;
        end
        front_reg    <= mem_rdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            head_reg   <= '0;
            count_reg  <= '0;
            wait_reg   <= '0;
            resend_reg <= '0;
            nmt_reg    <= NS_PREOP;
            err_reg    <= 1'b0;
            ev_reg     <= EV_NONE;
            pop_tx_reg <= 1'b0;
            loop_reg   <= 1'b0;
            strobe     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            count_reg  <= count_next;
            wait_reg   <= wait_next;
            resend_reg <= resend_next;
            nmt_reg    <= nmt_next;
            err_reg    <= err_next;
            ev_reg     <= ev_next;
            pop_tx_reg <= pop_tx_next;
            loop_reg   <= loop_next;
            strobe     <= o_strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind         <= o_kind_next;
        is_nmt       <= o_nmt_next;
        out_cmd      <= o_cmd_next;
        out_index    <= o_idx_next;
        out_subindex <= o_sub_next;
        out_payload  <= o_pay_next;
        last         <= o_last_next;
        device_error <= o_last_next & err_next;
        nmt_now      <= o_last_next ? nmt_next : NS_PREOP;
        event_res    <= o_last_next ? ev_next : EV_NONE;
    end

    assign busy = (state_reg != ST_IDLE);

    // push helper outcome: when queue was empty, a transmit walk follows
    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        count_next  = count_reg;
        wait_next   = wait_reg;
        resend_next = resend_reg;
        nmt_next    = nmt_reg;
        err_next    = err_reg;
        ev_next     = ev_reg;
        pop_tx_next = pop_tx_reg;
        loop_next   = loop_reg;
        mem_we      = 1'b0;
        mem_waddr   = wrap_add(head_reg, count_reg);
        mem_wdata   = '{hdr: enq_hdr, pay: pay_reg};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_DECODE;
                    ev_next    = EV_NONE;
                end
            end
            ST_DECODE:
            begin
                state_next = ST_STATUS;
                priority case (mode_reg)
                    MODE_ENQ:
                    begin
                        if (full)
                        begin
                            ev_next = EV_OVF;
                        end
                        else
                        begin
                            ev_next    = EV_OK;
                            mem_we     = 1'b1;
                            count_next = count_reg + 1'b1;
                            if (count_reg == '0)
                            begin
                                wait_next   = '0;
                                resend_next = '0;
                                pop_tx_next = 1'b1;
                                loop_next   = 1'b0;
                                state_next  = ST_RD;
                            end
                        end
                    end
                    MODE_ANS:
                    begin
                        if (front_match)
                        begin
                            ev_next    = EV_OK;
                            state_next = ST_NEXT_POP;
                            if (cmd_reg == SDO_ABORT)
                            begin
                                ev_next    = EV_ABORT;
                                err_next   = 1'b1;
                                state_next = ST_STOP_PUSH;
                            end
                        end
                        else
                        begin
                            ev_next = EV_UNEXP;
                        end
                    end
                    MODE_HB:
                    begin
                        ev_next = EV_BAD_HB;
                        if (flen_reg == 4'd1)
                        begin
                            if (cmd_reg == 8'h00 || cmd_reg == 8'h7F)
                            begin
                                nmt_next = NS_PREOP;
                                ev_next  = EV_OK;
                            end
                            else if (cmd_reg == 8'h04)
                            begin
                                nmt_next = NS_STOP;
                                ev_next  = EV_OK;
                            end
                            else if (cmd_reg == 8'h05)
                            begin
                                nmt_next = NS_OPER;
                                ev_next  = EV_OK;
                            end
                        end
                    end
                    MODE_TICK:
                    begin
                        if (timeout_reg != '0 && count_reg != '0)
                        begin
                            if (wait_reg != 17'h1FFFF)
                            begin
                                wait_next = wait_reg + 1'b1;
                            end
                            if (wait_reg > {1'b0, timeout_reg})
                            begin
                                if (resend_reg > {1'b0, resend_lim_reg})
                                begin
                                    ev_next = EV_TIMEOUT;
                                    if (!err_reg)
                                    begin
                                        err_next   = 1'b1;
                                        state_next = ST_STOP_PUSH;
                                    end
                                    else
                                    begin
                                        state_next = ST_NEXT_POP;
                                    end
                                end
                                else
                                begin
                                    if (resend_reg != 9'h1FF)
                                    begin
                                        resend_next = resend_reg + 1'b1;
                                    end
                                    ev_next     = EV_OK;
                                    pop_tx_next = 1'b0;
                                    loop_next   = 1'b0;
                                    state_next  = ST_RD;
                                end
                            end
                        end
                    end
                    MODE_NMT:
                    begin
                        if (cmd_reg == NMT_PREOP || cmd_reg == NMT_START
                            || cmd_reg == NMT_STOP)
                        begin
                            mem_wdata = '{hdr: nmt_hdr_in, pay: 32'd0};
                            if (hb_off_reg)
                            begin
                                nmt_next = (cmd_reg == NMT_PREOP) ? NS_PREOP :
                                           (cmd_reg == NMT_START) ? NS_OPER : NS_STOP;
                            end
                            if (full)
                            begin
                                ev_next = EV_OVF;
                            end
                            else
                            begin
                                ev_next    = EV_OK;
                                mem_we     = 1'b1;
                                count_next = count_reg + 1'b1;
                                if (count_reg == '0)
                                begin
                                    wait_next   = '0;
                                    resend_next = '0;
                                    pop_tx_next = 1'b1;
                                    loop_next   = 1'b0;
                                    state_next  = ST_RD;
                                end
                            end
                        end
                        else if (cmd_reg == NMT_RST_N || cmd_reg == NMT_RST_C)
                        begin
                            mem_wdata   = '{hdr: nmt_hdr_in, pay: 32'd0};
                            mem_waddr   = '0;
                            mem_we      = 1'b1;
                            head_next   = '0;
                            count_next  = CW'(1);
                            wait_next   = '0;
                            resend_next = '0;
                            err_next    = 1'b0;
                            ev_next     = EV_OK;
                            pop_tx_next = 1'b1;
                            loop_next   = 1'b0;
                            state_next  = ST_RD;
                        end
                    end
                    default: ;
                endcase
            end
            ST_STOP_PUSH:
            begin
                // outstanding request is at head, so the queue is not empty here
                mem_wdata  = '{hdr: stop_hdr, pay: 32'd0};
                if (hb_off_reg)
                begin
                    nmt_next = NS_STOP;
                end
                if (!full)
                begin
                    mem_we     = 1'b1;
                    count_next = count_reg + 1'b1;
                end
                state_next = ST_NEXT_POP;
            end
            ST_NEXT_POP:
            begin
                wait_next   = '0;
                resend_next = '0;
                if (count_reg != '0)
                begin
                    head_next  = wrap_add(head_reg, CW'(1));
                    count_next = count_reg - 1'b1;
                end
                pop_tx_next = 1'b1;
                loop_next   = 1'b1;
                state_next  = (count_reg > CW'(1)) ? ST_RD : ST_STATUS;
            end
            ST_RD:
            begin
                state_next = ST_RD_WAIT;
            end
            ST_RD_WAIT:
            begin
                state_next = ST_TX;
            end
            ST_TX:
            begin
                state_next = ST_STATUS;
                if (pop_tx_reg && !front_reg.hdr.ans)
                begin
                    head_next  = wrap_add(head_reg, CW'(1));
                    count_next = count_reg - 1'b1;
                    if (loop_reg && count_reg > CW'(1))
                    begin
                        state_next = ST_RD;
                    end
                end
            end
            ST_STATUS:
            begin
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        o_strobe_next = 1'b0;
        o_kind_next   = KIND_TX;
        o_nmt_next    = 1'b0;
        o_cmd_next    = '0;
        o_idx_next    = '0;
        o_sub_next    = '0;
        o_pay_next    = '0;
        o_last_next   = 1'b0;
        unique case (state_reg)
            ST_DECODE:
            begin
                if (mode_reg == MODE_ANS && front_match
                    && (cmd_reg == 8'h42 || cmd_reg == 8'h43
                        || cmd_reg == 8'h4B || cmd_reg == 8'h4F))
                begin
                    o_strobe_next = 1'b1;
                    o_kind_next   = KIND_ANS;
                    o_cmd_next    = cmd_reg;
                    o_idx_next    = idx_reg;
                    o_sub_next    = sub_reg;
                    o_pay_next    = pay_reg;
                end
            end
            ST_TX:
            begin
                o_strobe_next = 1'b1;
                o_nmt_next    = front_reg.hdr.nmt;
                o_cmd_next    = front_reg.hdr.cmd;
                o_idx_next    = front_reg.hdr.idx;
                o_sub_next    = front_reg.hdr.sub;
                o_pay_next    = front_reg.pay;
            end
            ST_STATUS:
            begin
                o_strobe_next = 1'b1;
                o_kind_next   = KIND_STAT;
                o_last_next   = 1'b1;
            end
            default: ;
        endcase
    end

`ifndef SYNTH
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("queue count beyond depth");
    a_last_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        last |-> strobe)
        else $error("final status without strobe");
    a_status_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STATUS) |=> (state_reg == ST_IDLE) && strobe && last)
        else $error("status not delivered");
`endif

endmodule
